/* rtl/epm_pkg.sv */
package epm_pkg;

   localparam int WORD_W    = 32;
   localparam int BYTE_W    = 8;
   localparam int TAP_W     = 7;
   localparam int ROT_W     = 5;
   localparam int OUT_IDX_W = 7;
   localparam int TAP_COUNT = 5;
   localparam int CSR_IDX_W = 3;
   localparam int RD_PORTS  = TAP_COUNT + 1;

   // item kinds
   typedef enum logic {
      REQ_MIX  = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_ONE   = 3'd0,
      CSR_TAP_TWO   = 3'd1,
      CSR_TAP_THREE = 3'd2,
      CSR_TAP_FOUR  = 3'd3,
      CSR_TAP_FIVE  = 3'd4
   } csr_index_type;

   localparam logic [TAP_W-1:0] TAP_RESET [TAP_COUNT] = '{
      7'd104, 7'd76, 7'd51, 7'd25, 7'd1
   };

   localparam logic [ROT_W-1:0] ROT_STEP      = 5'd7;
   localparam logic [ROT_W-1:0] ROT_STEP_WRAP = 5'd14;

   localparam logic [WORD_W-1:0] TWIST_TAB [8] = '{
      32'h00000000, 32'h3b6e20c8, 32'h76dc4190, 32'h4db26158,
      32'hedb88320, 32'hd6d6a3e8, 32'h9b64c2b0, 32'ha00ae278
   };

   // back end status seen by the front end
   typedef struct packed {
      logic clearing;
   } status_type;

endpackage

/* rtl/epm_if.sv */
interface epm_req_if;
   import epm_pkg::*;
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [BYTE_W-1:0]   data_byte;
   logic [TAP_W-1:0]    read_index;
   logic                final_byte;
   modport source (output valid, req_type, data_byte, read_index, final_byte, input ready);
   modport sink   (input valid, req_type, data_byte, read_index, final_byte, output ready);
endinterface

interface epm_rsp_if;
   import epm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OUT_IDX_W-1:0] word_index;
   logic [WORD_W-1:0]    word_value;
   logic                 final_echo;
   modport source (output valid, word_index, word_value, final_echo, input ready);
   modport sink   (input valid, word_index, word_value, final_echo, output ready);
endinterface

interface epm_csr_if;
   import epm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TAP_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/epm_ram.sv */
module epm_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 128,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];   // old data on a same-cycle write
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/epm_front.sv */
module epm_front #(
   parameter int POOL_WORDS = 128,
   localparam int IDX_W   = $clog2(POOL_WORDS),
   localparam int ENTRY_W = 2 + (epm_pkg::TAP_COUNT + 1) * IDX_W + epm_pkg::WORD_W
) (
   input  logic                 clock,
   input  logic                 reset,
   epm_req_if.sink              req,
   epm_csr_if.sink              csr,
   input  epm_pkg::status_type  status,
   output logic                 push_valid,
   input  logic                 push_ready,
   output logic [ENTRY_W-1:0]   push_data
);
   import epm_pkg::*;

   typedef struct packed {
      req_kind_type                   kind;
      logic                           fin;
      logic [IDX_W-1:0]               idx;
      logic [TAP_COUNT-1:0][IDX_W-1:0] taps;
      logic [WORD_W-1:0]              value;
   } entry_type;

   logic [TAP_W-1:0] tap_ff [TAP_COUNT];
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [ROT_W-1:0] rot_ff, rot_in;

   // 7-bit value modulo pool size, worked out at elaboration
   logic [IDX_W-1:0] mod_tab [1 << TAP_W];
   for (genvar g = 0; g < (1 << TAP_W); g++) begin : g_mod
      assign mod_tab[g] = IDX_W'(g % POOL_WORDS);
   end

   entry_type              entry;
   logic [IDX_W-1:0]       mix_idx;
   logic [2*WORD_W-1:0]    rot_dbl;
   logic [IDX_W:0]         tap_sum [TAP_COUNT];
   logic                   accept;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAP_COUNT; i++) begin
            tap_ff[i] <= TAP_RESET[i];
         end
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_TAP_ONE:   tap_ff[0] <= csr.data;
            CSR_TAP_TWO:   tap_ff[1] <= csr.data;
            CSR_TAP_THREE: tap_ff[2] <= csr.data;
            CSR_TAP_FOUR:  tap_ff[3] <= csr.data;
            CSR_TAP_FIVE:  tap_ff[4] <= csr.data;
            default: ;
         endcase
      end
   end

   assign mix_idx = (pos_ff == '0) ? IDX_W'(POOL_WORDS - 1) : pos_ff - 1'b1;
   assign rot_dbl = {WORD_W'(req.data_byte), WORD_W'(req.data_byte)} << rot_ff;

   always_comb begin
      entry.kind  = req_kind_type'(req.req_type);
      entry.fin   = req.final_byte;
      entry.value = rot_dbl[2*WORD_W-1:WORD_W];
      entry.idx   = (entry.kind == REQ_READ) ? mod_tab[req.read_index] : mix_idx;
      for (int t = 0; t < TAP_COUNT; t++) begin
         tap_sum[t] = {1'b0, mix_idx} + {1'b0, mod_tab[tap_ff[t]]};
         if (tap_sum[t] >= (IDX_W + 1)'(POOL_WORDS)) begin
            tap_sum[t] = tap_sum[t] - (IDX_W + 1)'(POOL_WORDS);
         end
         entry.taps[t] = tap_sum[t][IDX_W-1:0];
      end
   end

   assign push_valid = req.valid && !status.clearing;
   assign req.ready  = push_ready && !status.clearing;
   assign push_data  = entry;
   assign accept     = req.valid && req.ready;

   always_comb begin
      pos_in = pos_ff;
      rot_in = rot_ff;
      if (accept && entry.kind == REQ_MIX) begin
         pos_in = mix_idx;
         rot_in = rot_ff + ((mix_idx == '0) ? ROT_STEP_WRAP : ROT_STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         rot_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         rot_ff <= rot_in;
      end
   end

endmodule

/* rtl/epm_queue.sv */
module epm_queue #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = cnt_ff != CNT_W'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* rtl/epm_back.sv */
module epm_back #(
   parameter int POOL_WORDS = 128,
   localparam int IDX_W   = $clog2(POOL_WORDS),
   localparam int ENTRY_W = 2 + (epm_pkg::TAP_COUNT + 1) * IDX_W + epm_pkg::WORD_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  logic [ENTRY_W-1:0]   pop_data,
   output epm_pkg::status_type  status,
   epm_rsp_if.source            rsp
);
   import epm_pkg::*;

   typedef struct packed {
      req_kind_type                   kind;
      logic                           fin;
      logic [IDX_W-1:0]               idx;
      logic [TAP_COUNT-1:0][IDX_W-1:0] taps;
      logic [WORD_W-1:0]              value;
   } entry_type;

   entry_type         head;
   entry_type         s2_ff;
   logic              s2_valid_ff;
   logic              fwd_valid_ff;
   logic [IDX_W-1:0]  fwd_addr_ff;
   logic [WORD_W-1:0] fwd_data_ff;
   logic              clr_busy_ff;
   logic [IDX_W-1:0]  clr_addr_ff;
   logic              out_valid_ff;
   logic [IDX_W-1:0]  out_idx_ff;
   logic [WORD_W-1:0] out_word_ff;
   logic              out_fin_ff;

   logic [IDX_W-1:0]  rd_addr [RD_PORTS];
   logic [IDX_W-1:0]  s2_addr [RD_PORTS];
   logic [WORD_W-1:0] rd_data [RD_PORTS];
   logic [WORD_W-1:0] word   [RD_PORTS];
   logic [WORD_W-1:0] mix_w, new_word;
   logic              pop, s2_fire, s2_ready, wr_fire;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [WORD_W-1:0] ram_wdata;

   assign head = pop_data;

   always_comb begin
      rd_addr[0] = head.idx;
      s2_addr[0] = s2_ff.idx;
      for (int t = 0; t < TAP_COUNT; t++) begin
         rd_addr[t+1] = head.taps[t];
         s2_addr[t+1] = s2_ff.taps[t];
      end
   end

   // one bank per read port, all written alike
   for (genvar j = 0; j < RD_PORTS; j++) begin : g_bank
      epm_ram #(
         .WIDTH (WORD_W),
         .DEPTH (POOL_WORDS)
      ) u_bank (
         .clock (clock),
         .we    (ram_we),
         .waddr (ram_waddr),
         .wdata (ram_wdata),
         .re    (pop),
         .raddr (rd_addr[j]),
         .rdata (rd_data[j])
      );
   end

   // bypass the word written at the edge these reads were taken
   always_comb begin
      mix_w = s2_ff.value;
      for (int j = 0; j < RD_PORTS; j++) begin
         word[j] = (fwd_valid_ff && fwd_addr_ff == s2_addr[j]) ? fwd_data_ff : rd_data[j];
         mix_w   = mix_w ^ word[j];
      end
      if (s2_ff.kind == REQ_READ) begin
         new_word = word[0];
      end else begin
         new_word = (mix_w >> 3) ^ TWIST_TAB[mix_w[2:0]];
      end
   end

   assign s2_fire   = s2_valid_ff && (!out_valid_ff || rsp.ready);
   assign s2_ready  = !s2_valid_ff || s2_fire;
   assign pop_ready = s2_ready && !clr_busy_ff;
   assign pop       = pop_valid && pop_ready;
   assign wr_fire   = s2_fire && s2_ff.kind == REQ_MIX;

   assign ram_we    = clr_busy_ff || wr_fire;
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : s2_ff.idx;
   assign ram_wdata = clr_busy_ff ? '0 : new_word;

   assign status.clearing = clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s2_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == IDX_W'(POOL_WORDS - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (pop) begin
            s2_valid_ff  <= 1'b1;
            fwd_valid_ff <= wr_fire;
         end else if (s2_fire) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s2_ff       <= head;
         fwd_addr_ff <= s2_ff.idx;
         fwd_data_ff <= new_word;
      end
      if (s2_fire) begin
         out_idx_ff  <= s2_ff.idx;
         out_word_ff <= new_word;
         out_fin_ff  <= s2_ff.fin;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.word_index = OUT_IDX_W'(out_idx_ff);
   assign rsp.word_value = out_word_ff;
   assign rsp.final_echo = out_fin_ff;

endmodule

/* rtl/entropy_pool_mixer.sv */
// channel | dir | carries                                    | accepted when
// req     | in  | req_type, data_byte, read_index, final_byte | req.valid & req.ready
// rsp     | out | word_index, word_value, final_echo          | rsp.valid & rsp.ready
// csr     | in  | index (0..4 = tap_one..tap_five), data      | csr.valid (ready tied high)
//
// One item per cycle sustained while rsp.ready stays high and no clear is running; an item
// goes to a queue slot at the edge that takes it, then a bank read, then the output register.
// After reset the pool banks are swept to zero, one word a cycle; req.ready is low until
// the sweep ends; csr writes are taken throughout.
// rsp stalls back up through the output register, the mix stage and the queue to req.ready.
module entropy_pool_mixer #(
   parameter int POOL_WORDS  = 128,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   epm_req_if.sink    req,
   epm_rsp_if.source  rsp,
   epm_csr_if.sink    csr
);
   import epm_pkg::*;

   localparam int IDX_W   = $clog2(POOL_WORDS);
   localparam int ENTRY_W = 2 + (TAP_COUNT + 1) * IDX_W + WORD_W;

   status_type         status;
   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   // front: taps, add position and rotation; resolves all pool addresses
   epm_front #(
      .POOL_WORDS (POOL_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .status     (status),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // short queue decoupling front and back
   epm_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: six replicated pool banks, mix/twist, write-back bypass, result register
   epm_back #(
      .POOL_WORDS (POOL_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .status    (status),
      .rsp       (rsp)
   );

endmodule
